FILE: rtl/gated_audio_crossbar_top_assert.svh
// Assertion macros for the crossbar checker.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef GATED_AUDIO_CROSSBAR_TOP_ASSERT_SVH
`define GATED_AUDIO_CROSSBAR_TOP_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next, outside reset.
`define GAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gac checker: next-cycle property failed");

// Consequent holds in the cycle after reset is seen.
`define GAC_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("gac checker: state after reset is wrong");

`endif

FILE: rtl/gac_pkg.sv
`timescale 1ns / 1ps

package gac_pkg;

  // Sizes
  localparam int NUM_RIGS       = 8;
  localparam int RIG_W          = 3;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int BAND_COUNT     = 14;
  localparam int NUM_HAM_BANDS  = 13;
  localparam int BAND_W         = 4;
  localparam int GAIN_W         = 16;
  localparam int SAMPLE_W       = 16;
  localparam int FREQ_W         = 32;
  localparam int MODE_W         = 8;
  localparam int PB_W           = 14;
  localparam int CMD_W          = 2;
  localparam int RIG_DW         = FREQ_W + MODE_W;
  localparam int GAIN_DEPTH     = NUM_RIGS * NUM_RIGS * BAND_COUNT;
  localparam int GAIN_AW        = $clog2(GAIN_DEPTH);
  localparam int PROD_W         = GAIN_W + 1 + SAMPLE_W;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;

  localparam logic [BAND_W-1:0] BAND_OTHER = 4'd13;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'((1 << GAIN_FRAC_BITS) / 10);

  // Scaling constants
  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'((1 << GAIN_FRAC_BITS) - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX   = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN   = PROD_W'(-32768);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_GAIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TUNE     = 2'd2;

  // Register index (bit 2 of the byte address)
  localparam logic [0:0] REG_ROUTING_ENABLE = 1'b0;

  // Mode codes with a passband other than the voice default
  localparam logic [MODE_W-1:0] MODE_AM     = 8'h02;
  localparam logic [MODE_W-1:0] MODE_CW     = 8'h03;
  localparam logic [MODE_W-1:0] MODE_RTTY   = 8'h04;
  localparam logic [MODE_W-1:0] MODE_FM     = 8'h05;
  localparam logic [MODE_W-1:0] MODE_CW_R   = 8'h07;
  localparam logic [MODE_W-1:0] MODE_RTTY_R = 8'h08;
  localparam logic [MODE_W-1:0] MODE_DV     = 8'h17;

  // Passbands in Hz
  localparam logic [PB_W-1:0] PB_VOICE  = 14'd3000;
  localparam logic [PB_W-1:0] PB_WIDE   = 14'd5000;
  localparam logic [PB_W-1:0] PB_NARROW = 14'd500;
  localparam logic [PB_W-1:0] PB_FM     = 14'd10000;

  // Band edges in Hz, inclusive
  localparam logic [FREQ_W-1:0] BAND_LO [NUM_HAM_BANDS] = '{
    32'd1800000, 32'd3500000, 32'd5250000, 32'd7000000, 32'd10100000,
    32'd14000000, 32'd18068000, 32'd21000000, 32'd24890000, 32'd28000000,
    32'd50000000, 32'd144000000, 32'd430000000
  };
  localparam logic [FREQ_W-1:0] BAND_HI [NUM_HAM_BANDS] = '{
    32'd2000000, 32'd4000000, 32'd5450000, 32'd7300000, 32'd10150000,
    32'd14350000, 32'd18168000, 32'd21450000, 32'd24990000, 32'd29700000,
    32'd54000000, 32'd148000000, 32'd450000000
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRC,
    ST_BAND,
    ST_READ,
    ST_EVAL,
    ST_SCALE,
    ST_FLUSH
  } gac_state_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic clear_wr;
    logic src_load;
    logic band_load;
    logic dst_read;
    logic eval_load;
    logic scale_step;
    logic flush;
  } gac_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic in_valid;
    logic in_is_sample;
    logic dst_last;
    logic deliver;
    logic pend_valid;
    logic out_free;
  } gac_status_t;

  function automatic logic [PB_W-1:0] passband(input logic [MODE_W-1:0] mode);
    logic [PB_W-1:0] pb;
    case (mode) inside
      MODE_AM, MODE_DV:                        pb = PB_WIDE;
      MODE_CW, MODE_RTTY, MODE_CW_R, MODE_RTTY_R: pb = PB_NARROW;
      MODE_FM:                                 pb = PB_FM;
      default:                                 pb = PB_VOICE;
    endcase
    return pb;
  endfunction

  // Lowest matching band wins
  function automatic logic [BAND_W-1:0] band_of(input logic [FREQ_W-1:0] hz);
    logic [BAND_W-1:0] b;
    b = BAND_OTHER;
    for (int i = NUM_HAM_BANDS - 1; i >= 0; i--) begin
      if (hz >= BAND_LO[i] && hz <= BAND_HI[i]) begin
        b = BAND_W'(i);
      end
    end
    return b;
  endfunction

  function automatic logic [GAIN_AW-1:0] gain_addr(input logic [RIG_W-1:0] src,
                                                   input logic [RIG_W-1:0] dst,
                                                   input logic [BAND_W-1:0] band);
    return GAIN_AW'((int'(src) * NUM_RIGS + int'(dst)) * BAND_COUNT + int'(band));
  endfunction

endpackage

FILE: rtl/gac_if.sv
`timescale 1ns / 1ps

// Command channel
interface gac_in_if;
  import gac_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [RIG_W-1:0]           rig_index;
  logic [RIG_W-1:0]           peer_index;
  logic [BAND_W-1:0]          band_index;
  logic [GAIN_W-1:0]          gain_value;
  logic [FREQ_W-1:0]          frequency_hz;
  logic [MODE_W-1:0]          mode_code;
  logic                       rig_present;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, command, rig_index, peer_index, band_index, gain_value,
                  frequency_hz, mode_code, rig_present, sample, input ready);
  modport sink (input valid, command, rig_index, peer_index, band_index, gain_value,
                frequency_hz, mode_code, rig_present, sample, output ready);
endinterface

// Result channel
interface gac_out_if;
  import gac_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [RIG_W-1:0]           dest_rig;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last;

  modport source (output valid, dest_rig, sample_out, last, input ready);
  modport sink (input valid, dest_rig, sample_out, last, output ready);
endinterface

FILE: rtl/gac_ram.sv
`timescale 1ns / 1ps

module gac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/gac_ctrl.sv
`timescale 1ns / 1ps

module gac_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gac_pkg::gac_status_t status,
  output gac_pkg::gac_cmd_t    cmd
);
  import gac_pkg::*;

  gac_state_t state_r;
  gac_state_t state_nxt;
  logic       scale_hold;

  // A delivered sample cannot move on while the older one is stuck behind the output
  assign scale_hold = status.deliver && status.pend_valid && !status.out_free;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (status.in_valid && status.in_is_sample) state_nxt = ST_SRC;
      end
      ST_SRC:  state_nxt = ST_BAND;
      ST_BAND: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (!scale_hold) state_nxt = status.dst_last ? ST_FLUSH : ST_READ;
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: cmd.clear_wr  = 1'b1;
      ST_IDLE:  cmd.in_ready  = 1'b1;
      ST_SRC:   cmd.src_load  = 1'b1;
      ST_BAND:  cmd.band_load = 1'b1;
      ST_READ:  cmd.dst_read  = 1'b1;
      ST_EVAL:  cmd.eval_load = 1'b1;
      ST_SCALE: cmd.scale_step = !scale_hold;
      ST_FLUSH: cmd.flush     = status.pend_valid && status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: rtl/gac_datapath.sv
`timescale 1ns / 1ps

module gac_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  gac_in_if.sink               in_chan,
  gac_out_if.source            out_chan,
  input  logic                 route_en,
  input  gac_pkg::gac_cmd_t    cmd,
  output gac_pkg::gac_status_t status
);
  import gac_pkg::*;

  // Command decode at transfer
  logic accept;
  logic acc_sample;
  logic acc_tune;
  logic acc_gain;

  // Control registers
  logic [NUM_RIGS-1:0] valid_r, valid_nxt;
  logic [GAIN_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [RIG_W-1:0]    dst_r, dst_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers
  logic [RIG_W-1:0]           src_r;
  logic signed [SAMPLE_W-1:0] s_r;
  logic [FREQ_W-1:0]          sf_r;
  logic [MODE_W-1:0]          sm_r;
  logic [BAND_W-1:0]          band_r;
  logic [PB_W-1:0]            pb_r;
  logic [FREQ_W-1:0]          diff_r;
  logic                       mode_eq_r;
  logic                       gate_r;
  logic                       self_r;
  logic signed [PROD_W-1:0]   product_r;
  logic [RIG_W-1:0]           pend_dest_r;
  logic signed [SAMPLE_W-1:0] pend_sample_r;
  logic [RIG_W-1:0]           out_dest_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  // Memory ports
  logic                rig_we;
  logic                rig_re;
  logic [RIG_W-1:0]    rig_raddr;
  logic [RIG_DW-1:0]   rig_rdata;
  logic                gain_we;
  logic [GAIN_AW-1:0]  gain_waddr;
  logic [GAIN_W-1:0]   gain_wdata;
  logic [GAIN_W-1:0]   gain_rdata;

  // Evaluation and scaling
  logic [FREQ_W-1:0]          df;
  logic [MODE_W-1:0]          dm;
  logic signed [PROD_W-1:0]   adj;
  logic signed [PROD_W-1:0]   quo;
  logic signed [SAMPLE_W-1:0] scaled;
  logic                       deliver;
  logic                       out_free;
  logic                       out_load;

  assign in_chan.ready = cmd.in_ready;
  assign accept     = in_chan.valid && cmd.in_ready;
  assign acc_sample = accept && (in_chan.command == CMD_SAMPLE);
  assign acc_tune   = accept && (in_chan.command == CMD_TUNE) &&
                      (int'(in_chan.rig_index) < NUM_RIGS);
  assign acc_gain   = accept && (in_chan.command == CMD_SET_GAIN) &&
                      (int'(in_chan.rig_index) < NUM_RIGS) &&
                      (int'(in_chan.peer_index) < NUM_RIGS) &&
                      (int'(in_chan.band_index) < BAND_COUNT);

  // Rig table: frequency and mode; only used behind a set present bit
  assign rig_we    = acc_tune;
  assign rig_re    = acc_sample || cmd.dst_read;
  assign rig_raddr = cmd.dst_read ? dst_r : in_chan.rig_index;

  gac_ram #(
    .WIDTH (RIG_DW),
    .DEPTH (NUM_RIGS)
  ) u_rig_ram (
    .clk   (clk),
    .we    (rig_we),
    .waddr (in_chan.rig_index),
    .wdata ({in_chan.frequency_hz, in_chan.mode_code}),
    .re    (rig_re),
    .raddr (rig_raddr),
    .rdata (rig_rdata)
  );

  // Gain table: clearing sweep after reset, else set-gain writes
  assign gain_we    = cmd.clear_wr || acc_gain;
  assign gain_waddr = cmd.clear_wr ? clr_cnt_r :
                      gain_addr(in_chan.rig_index, in_chan.peer_index, in_chan.band_index);
  assign gain_wdata = cmd.clear_wr ? GAIN_RESET : in_chan.gain_value;

  gac_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (GAIN_DEPTH)
  ) u_gain_ram (
    .clk   (clk),
    .we    (gain_we),
    .waddr (gain_waddr),
    .wdata (gain_wdata),
    .re    (cmd.dst_read),
    .raddr (gain_addr(src_r, dst_r, band_r)),
    .rdata (gain_rdata)
  );

  assign df = rig_rdata[RIG_DW-1:MODE_W];
  assign dm = rig_rdata[MODE_W-1:0];

  // Truncate toward zero, then saturate to the sample range
  always_comb begin
    adj = product_r + (product_r[PROD_W-1] ? ROUND_ADD : SAT_MAX - SAT_MAX);
    quo = adj >>> GAIN_FRAC_BITS;
    if (quo > SAT_MAX) begin
      scaled = SAT_MAX[SAMPLE_W-1:0];
    end else if (quo < SAT_MIN) begin
      scaled = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      scaled = quo[SAMPLE_W-1:0];
    end
  end

  // Gate: skip self, and when routing is on, present destinations failing mode or passband
  assign deliver  = !self_r &&
                    !(gate_r && !(mode_eq_r && (diff_r <= FREQ_W'(pb_r))));
  assign out_free = !out_valid_r || out_chan.ready;
  assign out_load = (cmd.scale_step && deliver && pend_valid_r) ||
                    (cmd.flush && pend_valid_r);

  // Control next values
  always_comb begin
    valid_nxt      = valid_r;
    clr_cnt_nxt    = clr_cnt_r;
    dst_nxt        = dst_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    if (acc_tune) valid_nxt[in_chan.rig_index] = in_chan.rig_present;
    if (cmd.clear_wr) clr_cnt_nxt = clr_cnt_r + 1'b1;
    if (acc_sample) dst_nxt = '0;
    if (cmd.scale_step) dst_nxt = dst_r + 1'b1;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    if (cmd.scale_step && deliver) pend_valid_nxt = 1'b1;
    if (cmd.flush && pend_valid_r) pend_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      clr_cnt_r    <= '0;
      dst_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      dst_r        <= dst_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (acc_sample) begin
      src_r <= in_chan.rig_index;
      s_r   <= in_chan.sample;
    end
    // An absent source counts as frequency 0, mode 0
    if (cmd.src_load) begin
      sf_r <= valid_r[src_r] ? df : '0;
      sm_r <= valid_r[src_r] ? dm : '0;
    end
    if (cmd.band_load) begin
      band_r <= valid_r[src_r] ? band_of(sf_r) : BAND_OTHER;
      pb_r   <= passband(sm_r);
    end
    if (cmd.eval_load) begin
      diff_r    <= (sf_r >= df) ? (sf_r - df) : (df - sf_r);
      mode_eq_r <= (sm_r == dm);
      gate_r    <= route_en && valid_r[dst_r];
      self_r    <= (dst_r == src_r);
      product_r <= $signed({1'b0, gain_rdata}) * s_r;
    end
    if (cmd.scale_step && deliver) begin
      pend_dest_r   <= dst_r;
      pend_sample_r <= scaled;
    end
    if (out_load) begin
      out_dest_r   <= pend_dest_r;
      out_sample_r <= pend_sample_r;
      out_last_r   <= cmd.flush;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.dest_rig   = out_dest_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.last       = out_last_r;

  // Status
  assign status.clear_done   = (clr_cnt_r == GAIN_AW'(GAIN_DEPTH - 1));
  assign status.in_valid     = in_chan.valid;
  assign status.in_is_sample = (in_chan.command == CMD_SAMPLE);
  assign status.dst_last     = (dst_r == RIG_W'(NUM_RIGS - 1));
  assign status.deliver      = deliver;
  assign status.pend_valid   = pend_valid_r;
  assign status.out_free     = out_free;

endmodule

FILE: rtl/gated_audio_crossbar_top.sv
`timescale 1ns / 1ps

// Audio crossbar for eight rigs. Tune and set-gain commands are accepted
// back to back. A sample command runs from its transfer to the next possible
// input transfer in steps: fetch the source rig and its band, then for each
// of the eight rigs in turn, the source itself included, read the rig and
// gain tables, compare and multiply, scale and saturate; then hand over the
// final result and go back to idle, which takes the next transfer. A stalled
// output can hold the scaling and hand-over steps. The per-destination loop
// runs through the single read port of each table.
// After reset the gain table is swept to its reset gain, all 896 entries,
// during which no input is accepted; register writes are taken throughout.
// Results of one sample leave in ascending destination order, the final one
// flagged with last; a sample that reaches no destination yields no result.
module gated_audio_crossbar_top (
  input  logic                       clk,
  input  logic                       rst_n,
  gac_in_if.sink                     in_chan,
  gac_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [gac_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [gac_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [gac_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import gac_pkg::*;

  gac_cmd_t    cmd;
  gac_status_t status;
  logic        cfg_wr;
  logic        reg_sel;
  logic        route_en_r, route_en_nxt;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = (cfg_paddr[2:2] == REG_ROUTING_ENABLE);

  always_comb begin
    route_en_nxt = route_en_r;
    if (cfg_wr && reg_sel) route_en_nxt = cfg_pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_en_r <= 1'b1;
    end else begin
      route_en_r <= route_en_nxt;
    end
  end

  assign cfg_prdata = reg_sel ? {{(CFG_DW-1){1'b0}}, route_en_r} : '0;

  gac_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  gac_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .route_en (route_en_r),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

FILE: rtl/gac_checker.sv
`timescale 1ns / 1ps
`include "gated_audio_crossbar_top_assert.svh"

module gac_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [gac_pkg::CMD_W-1:0]           in_command,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [gac_pkg::RIG_W-1:0]           out_dest_rig,
  input logic signed [gac_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                                out_last
);
  import gac_pkg::*;

  // Hold a stalled result
  `GAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `GAC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_dest_rig) && $stable(out_sample_out) && $stable(out_last))

  // A sample transfer occupies the block for its fan-out
  `GAC_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && (in_command == CMD_SAMPLE), !in_ready)

  // Reset starts the clearing sweep with nothing to deliver
  `GAC_ASSERT_AFTER_RESET(a_reset_quiet, !in_ready && !out_valid)

endmodule

bind gated_audio_crossbar_top gac_checker u_gac_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_command     (in_chan.command),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_dest_rig   (out_chan.dest_rig),
  .out_sample_out (out_chan.sample_out),
  .out_last       (out_chan.last)
);
